FILE: hw/rtl/url_percent_encoder_core_assert.svh
// Assertion macros for the checker file of the encoder core.
// Both macros expect clk and rst_n in scope and stay quiet while reset is low.
`ifndef URL_PERCENT_ENCODER_CORE_ASSERT_SVH
`define URL_PERCENT_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication.
`define URE_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define URE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

FILE: hw/rtl/ure_pkg.sv
// ----------------------------------------------------------------------------
// ure_pkg
// Types, character constants and helpers shared by the URL encoder modules.
// ----------------------------------------------------------------------------
package ure_pkg;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  localparam logic [127:0] HEX_STR = "0123456789ABCDEF";

  // Output slots of one command, emitted in ascending order when enabled.
  localparam int SLOT_COUNT = 13;
  localparam logic [3:0] SLOT_PRE_PCT    = 4'd0;   // "%25" for a dropped held '%'
  localparam logic [3:0] SLOT_PRE_TWO    = 4'd1;
  localparam logic [3:0] SLOT_PRE_FIVE   = 4'd2;
  localparam logic [3:0] SLOT_PAIR_PCT   = 4'd3;   // '%' of a valid escape
  localparam logic [3:0] SLOT_OLD_DIGIT  = 4'd4;   // previously held hex digit
  localparam logic [3:0] SLOT_RAW        = 4'd5;   // input byte as is
  localparam logic [3:0] SLOT_ESC_PCT    = 4'd6;   // input byte escaped
  localparam logic [3:0] SLOT_ESC_HI     = 4'd7;
  localparam logic [3:0] SLOT_ESC_LO     = 4'd8;
  localparam logic [3:0] SLOT_TAIL_PCT   = 4'd9;   // flush of a '%' held at end
  localparam logic [3:0] SLOT_TAIL_TWO   = 4'd10;
  localparam logic [3:0] SLOT_TAIL_FIVE  = 4'd11;
  localparam logic [3:0] SLOT_TAIL_DIGIT = 4'd12;  // flush of a digit held at end

  typedef logic [SLOT_COUNT-1:0] slot_mask_t;

  typedef struct packed {
    slot_mask_t  mask;
    logic [7:0]  old_digit;
    logic [7:0]  data;
    logic        last;
  } ure_cmd_t;

  typedef enum logic [2:0] {
    HOLD_NONE  = 3'b001,
    HOLD_PCT   = 3'b010,
    HOLD_DIGIT = 3'b100
  } hold_state_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    hex_char = HEX_STR[{~nib, 3'b000} +: 8];
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    case (c) inside
      [CH_ZERO:CH_NINE], [CH_UP_A:CH_UP_F], [CH_LOW_A:CH_LOW_F]: is_hex = 1'b1;
      default:                                                  is_hex = 1'b0;
    endcase
  endfunction

  // Letters, digits and the unreserved/reserved punctuation that passes as is.
  function automatic logic passes(input logic [7:0] c);
    case (c) inside
      [CH_ZERO:CH_NINE], [CH_UP_A:CH_UP_Z], [CH_LOW_A:CH_LOW_Z]: passes = 1'b1;
      // ! $ & ' ( ) * + , - . /
      8'h21, 8'h24, [8'h26:8'h2F]:                                passes = 1'b1;
      // : ; = [ ] _
      8'h3A, 8'h3B, 8'h3D, 8'h5B, 8'h5D, 8'h5F:                  passes = 1'b1;
      CH_QMARK, CH_AT, CH_TILDE:                                  passes = 1'b1;
      default:                                                    passes = 1'b0;
    endcase
  endfunction

endpackage

FILE: hw/rtl/ure_queue.sv
// ----------------------------------------------------------------------------
// ure_queue
// Small register FIFO of encode commands between the front and back ends.
// ----------------------------------------------------------------------------
module ure_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ure_pkg::ure_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output ure_pkg::ure_cmd_t head_cmd,
  output logic              empty
);
  import ure_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ure_cmd_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: hw/rtl/ure_front.sv
// ----------------------------------------------------------------------------
// ure_front
// Accepts input bytes, tracks the held '%' and digit, and turns each byte
// into a command that enables the output slots it produces.
// ----------------------------------------------------------------------------
module ure_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              in_tlast,
  output logic              push,
  output ure_pkg::ure_cmd_t push_cmd,
  input  logic              q_full
);
  import ure_pkg::*;

  hold_state_t hold_r, hold_nxt, hold_after;
  logic [7:0]  digit_r, digit_nxt;
  slot_mask_t  mask, fresh_mask, pre_mask, tail_mask;
  logic        accept, b_hex, b_pct;
  hold_state_t fresh_hold;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;
  assign b_hex     = is_hex(in_tdata);
  assign b_pct     = (in_tdata == CH_PCT);

  always_comb begin
    fresh_mask = '0;
    fresh_hold = HOLD_NONE;
    if (b_pct) begin
      fresh_hold = HOLD_PCT;
    end else if (passes(in_tdata)) begin
      fresh_mask[SLOT_RAW] = 1'b1;
    end else begin
      fresh_mask[SLOT_ESC_PCT] = 1'b1;
      fresh_mask[SLOT_ESC_HI]  = 1'b1;
      fresh_mask[SLOT_ESC_LO]  = 1'b1;
    end

    pre_mask = '0;
    pre_mask[SLOT_PRE_PCT]  = 1'b1;
    pre_mask[SLOT_PRE_TWO]  = 1'b1;
    pre_mask[SLOT_PRE_FIVE] = 1'b1;

    tail_mask = '0;
    tail_mask[SLOT_TAIL_PCT]  = 1'b1;
    tail_mask[SLOT_TAIL_TWO]  = 1'b1;
    tail_mask[SLOT_TAIL_FIVE] = 1'b1;
  end

  always_comb begin
    mask       = '0;
    hold_after = HOLD_NONE;
    digit_nxt  = digit_r;
    unique case (hold_r)
      HOLD_NONE: begin
        mask       = fresh_mask;
        hold_after = fresh_hold;
      end
      HOLD_PCT: begin
        if (b_hex) begin
          hold_after = HOLD_DIGIT;
          digit_nxt  = in_tdata;
        end else begin
          mask       = pre_mask | fresh_mask;
          hold_after = fresh_hold;
        end
      end
      HOLD_DIGIT: begin
        if (b_hex) begin
          mask[SLOT_PAIR_PCT]  = 1'b1;
          mask[SLOT_OLD_DIGIT] = 1'b1;
          mask[SLOT_RAW]       = 1'b1;
        end else begin
          mask                 = pre_mask | fresh_mask;
          mask[SLOT_OLD_DIGIT] = 1'b1;
          hold_after           = fresh_hold;
        end
      end
      default: begin
        mask       = '0;
        hold_after = HOLD_NONE;
      end
    endcase

    hold_nxt = hold_after;
    if (in_tlast) begin
      // flush whatever is still held; a held digit is always this byte
      if (hold_after != HOLD_NONE) begin
        mask = mask | tail_mask;
      end
      if (hold_after == HOLD_DIGIT) begin
        mask[SLOT_TAIL_DIGIT] = 1'b1;
      end
      hold_nxt  = HOLD_NONE;
      digit_nxt = '0;
    end
  end

  assign push               = accept && (mask != '0);
  assign push_cmd.mask      = mask;
  assign push_cmd.old_digit = digit_r;
  assign push_cmd.data      = in_tdata;
  assign push_cmd.last      = in_tlast;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r  <= HOLD_NONE;
      digit_r <= '0;
    end else if (accept) begin
      hold_r  <= hold_nxt;
      digit_r <= digit_nxt;
    end
  end

endmodule

FILE: hw/rtl/ure_back.sv
// ----------------------------------------------------------------------------
// ure_back
// Expands queued commands into output bytes, one enabled slot per cycle
// while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module ure_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  ure_pkg::ure_cmd_t q_head,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast
);
  import ure_pkg::*;

  ure_cmd_t   cur_r, cur_nxt;
  logic       out_tvalid_r;
  logic [7:0] out_tdata_r;
  logic       out_tlast_r;
  logic       can_emit;
  logic [3:0] slot_idx;
  slot_mask_t mask_after;
  logic [7:0] slot_byte;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // lowest enabled slot goes first
  always_comb begin
    slot_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (cur_r.mask[i]) begin
        slot_idx = 4'(i);
      end
    end
  end

  assign can_emit   = (cur_r.mask != '0) && (!out_tvalid_r || out_tready);
  assign mask_after = can_emit ? (cur_r.mask & (cur_r.mask - 1'b1)) : cur_r.mask;
  assign q_pop      = (mask_after == '0) && !q_empty;

  always_comb begin
    cur_nxt      = cur_r;
    cur_nxt.mask = mask_after;
    if (q_pop) begin
      cur_nxt = q_head;
    end
  end

  always_comb begin
    unique case (slot_idx) inside
      SLOT_PRE_PCT, SLOT_PAIR_PCT, SLOT_ESC_PCT, SLOT_TAIL_PCT: slot_byte = CH_PCT;
      SLOT_PRE_TWO, SLOT_TAIL_TWO:                              slot_byte = CH_TWO;
      SLOT_PRE_FIVE, SLOT_TAIL_FIVE:                            slot_byte = CH_FIVE;
      SLOT_OLD_DIGIT:                                           slot_byte = cur_r.old_digit;
      SLOT_ESC_HI:                                    slot_byte = hex_char(cur_r.data[7:4]);
      SLOT_ESC_LO:                                    slot_byte = hex_char(cur_r.data[3:0]);
      default:                                                  slot_byte = cur_r.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      cur_r <= cur_nxt;
      if (can_emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_emit) begin
      out_tdata_r <= slot_byte;
      out_tlast_r <= cur_r.last && (mask_after == '0);
    end
  end

endmodule

FILE: hw/rtl/url_percent_encoder_core.sv
// ----------------------------------------------------------------------------
// url_percent_encoder_core
// Streaming URL percent-encoder: one raw byte in, zero to seven encoded
// bytes out, with the end-of-string mark carried to the last encoded byte.
// ----------------------------------------------------------------------------
// Input channel in_*: one string byte per request, in_tlast on its final byte.
// Output channel out_*: one encoded byte per request, out_tlast on the final
// encoded byte of the string.
// The front end takes a request in any cycle in which the command queue has
// room and turns it into a slot mask; a '%' or a '%' plus one hex digit may be
// held back until the following byte shows whether they form an escape.
// The back end drains one slot per cycle into the output register unless
// out_tready holds it back; an item yields as many bytes as its mask enables:
// 1 for a pass-through byte, 3 for an escaped one, up to 7.
// A request passes a queue entry and cur_r before reaching the output register.
// Reset (rst_n low, synchronous) empties the queue and drops any held bytes.
// While out_tready is low the output byte holds; the queue of QUEUE_DEPTH
// commands keeps taking input until full, then in_tready drops.
// ----------------------------------------------------------------------------
module url_percent_encoder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);
  import ure_pkg::*;

  logic     q_push, q_full, q_pop, q_empty;
  ure_cmd_t q_push_cmd, q_head_cmd;

  ure_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .q_full    (q_full)
  );

  ure_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_cmd (q_head_cmd),
    .empty    (q_empty)
  );

  ure_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: hw/rtl/ure_checker.sv
// ----------------------------------------------------------------------------
// ure_checker
// Port-level checks on the encoded output stream, bound to the core.
// ----------------------------------------------------------------------------
`include "url_percent_encoder_core_assert.svh"

module ure_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);
  import ure_pkg::*;

  logic after_pct_r;
  logic out_legal;
  logic out_hex;

  assign out_legal = (out_tdata == CH_PCT) || passes(out_tdata);
  assign out_hex   = is_hex(out_tdata);

  // remember whether the previous delivered byte opened an escape
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      after_pct_r <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      after_pct_r <= (out_tdata == CH_PCT);
    end
  end

  `URE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  `URE_ASSERT_IMPLIES(a_out_charset, out_tvalid, out_legal)
  `URE_ASSERT_IMPLIES(a_last_not_pct, out_tvalid && out_tlast, out_tdata != CH_PCT)
  `URE_ASSERT_IMPLIES(a_hex_after_pct, out_tvalid && after_pct_r, out_hex)

endmodule

bind url_percent_encoder_core ure_checker u_ure_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
